// File: hdl/hlt_pkg.sv
// Shared types and constants for the heartbeat liveness table.
// Holds the table size, operation, result and status codes, and the entry
// and write request structures. Depends on nothing.
package hlt_pkg;

    // Table geometry.
    localparam int PEER_SLOTS = 16;
    localparam int SLOT_W     = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PEER_SLOTS - 1);

    // Field widths.
    localparam int ID_W     = 32;
    localparam int TIME_W   = 64;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

    // Reset value of the dead threshold.
    localparam logic [31:0] THRESHOLD_RESET = 32'd300;

    // Request operation codes. The undefined code is taken but does nothing.
    localparam logic [1:0] OP_HEARTBEAT = 2'd0;
    localparam logic [1:0] OP_TICK      = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;
    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_HEARTBEAT = 2'd0;
    localparam logic [1:0] KIND_DEAD      = 2'd1;
    localparam logic [1:0] KIND_SWEEP_END = 2'd2;
    localparam logic [1:0] KIND_STATUS    = 2'd3;

    // Peer status codes.
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_ALIVE   = 2'd1;
    localparam logic [1:0] ST_SUSPECT = 2'd2;
    localparam logic [1:0] ST_DEAD    = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // One table entry.
    typedef struct packed {
        logic [ID_W-1:0]   node;
        logic [TIME_W-1:0] last_seen;
        logic [1:0]        status;
    } t_entry;

    // Write request to the entry store.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_entry            data;
    } t_ram_wr;

endpackage

// File: hdl/hlt_entry_ram.sv
// Entry store of the heartbeat liveness table: node id, last-seen time
// and status per slot, one write and one registered read per cycle.
// Depends on hlt_pkg.
module hlt_entry_ram (
    input  logic                      i_clk,
    input  hlt_pkg::t_ram_wr          i_wr,
    input  logic [hlt_pkg::SLOT_W-1:0] i_raddr,
    output hlt_pkg::t_entry           o_rdata
);
    import hlt_pkg::*;

    t_entry r_mem [PEER_SLOTS];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/heartbeat_liveness_table.sv
// Heartbeat liveness table, top level: request sequencer, active bits,
// configuration registers and result register. Depends on hlt_pkg and
// hlt_entry_ram.
//
// A request is taken when i_start is high and o_busy is low. An ignored
// heartbeat (id zero or the local id) answers in the next cycle and leaves
// the block ready; op 3 is taken and does nothing. Every other request walks
// the whole table through the single read port of the entry store, one slot
// a cycle, holding o_busy through the walk and its finish step, and its last
// result appears in the same cycle that o_busy falls, when a new request may
// already be taken. A sweep gives one peer-dead result per newly dead peer
// during the walk, in slot order, then a sweep-finished result.
// Results are held for one cycle, marked by o_valid, and cannot be stalled.
// Configuration writes are always accepted and should be made while the
// block is idle.
module heartbeat_liveness_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_op,
    input  logic [hlt_pkg::ID_W-1:0]      i_node_id,
    input  logic [hlt_pkg::TIME_W-1:0]    i_now,
    // Result channel
    output logic                          o_valid,
    output logic [1:0]                    o_kind,
    output logic [hlt_pkg::ID_W-1:0]      o_peer_id,
    output logic [1:0]                    o_peer_status,
    output logic                          o_came_back,
    output logic                          o_ignored,
    output logic                          o_table_full,
    output logic                          o_last,
    // Configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hlt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import hlt_pkg::*;

    // Control state
    t_state                r_state, n_state;
    logic [PEER_SLOTS-1:0] r_active, n_active;
    logic                  r_issue, n_issue;
    logic                  r_dvld, n_dvld;
    logic                  r_found, n_found;
    logic                  r_free_found, n_free_found;
    logic                  r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [SLOT_W-1:0]     r_didx, n_didx;

    // Request and search payload
    logic [1:0]            r_op, n_op;
    logic [ID_W-1:0]       r_id, n_id;
    logic [TIME_W-1:0]     r_now, n_now;
    logic [SLOT_W-1:0]     r_match_idx, n_match_idx;
    logic [1:0]            r_match_st, n_match_st;
    logic [SLOT_W-1:0]     r_free_idx, n_free_idx;

    // Configuration
    logic [ID_W-1:0]       r_local_id;
    logic [31:0]           r_threshold;

    // Result register
    logic [1:0]            r_kind, n_kind;
    logic [ID_W-1:0]       r_peer_id, n_peer_id;
    logic [1:0]            r_peer_status, n_peer_status;
    logic                  r_came_back, n_came_back;
    logic                  r_ignored, n_ignored;
    logic                  r_table_full, n_table_full;
    logic                  r_last, n_last;

    // Entry store
    t_ram_wr               ram_wr;
    t_entry                rd;

    // Shared compare unit
    logic [TIME_W-1:0]     silence;
    logic [TIME_W-1:0]     thr_full;
    logic [TIME_W-1:0]     thr_half;
    logic                  swept;
    logic                  hit;

    hlt_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_raddr (r_idx),
        .o_rdata (rd)
    );

    // Silence of the slot whose data has just come out of the store.
    assign silence  = r_now - rd.last_seen;
    assign thr_full = {{(TIME_W-32){1'b0}}, r_threshold};
    assign thr_half = thr_full >> 1;
    assign swept    = r_active[r_didx] && (rd.status != ST_DEAD);
    assign hit      = r_active[r_didx] && (rd.node == r_id);

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_id  <= '0;
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_LOCAL_ID) begin
                r_local_id <= i_cfg_data;
            end else if (i_cfg_index == CFG_THRESHOLD) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    // Control and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= '0;
            r_issue      <= 1'b0;
            r_dvld       <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_didx       <= '0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_issue      <= n_issue;
            r_dvld       <= n_dvld;
            r_found      <= n_found;
            r_free_found <= n_free_found;
            r_out_valid  <= n_out_valid;
            r_idx        <= n_idx;
            r_didx       <= n_didx;
        end
        r_op          <= n_op;
        r_id          <= n_id;
        r_now         <= n_now;
        r_match_idx   <= n_match_idx;
        r_match_st    <= n_match_st;
        r_free_idx    <= n_free_idx;
        r_kind        <= n_kind;
        r_peer_id     <= n_peer_id;
        r_peer_status <= n_peer_status;
        r_came_back   <= n_came_back;
        r_ignored     <= n_ignored;
        r_table_full  <= n_table_full;
        r_last        <= n_last;
    end

    // Sequencer: next state, store writes and results.
    always_comb begin
        n_state       = r_state;
        n_active      = r_active;
        n_issue       = r_issue;
        n_dvld        = 1'b0;
        n_found       = r_found;
        n_free_found  = r_free_found;
        n_idx         = r_idx;
        n_didx        = r_didx;
        n_op          = r_op;
        n_id          = r_id;
        n_now         = r_now;
        n_match_idx   = r_match_idx;
        n_match_st    = r_match_st;
        n_free_idx    = r_free_idx;
        n_out_valid   = 1'b0;
        n_kind        = r_kind;
        n_peer_id     = r_peer_id;
        n_peer_status = r_peer_status;
        n_came_back   = 1'b0;
        n_ignored     = 1'b0;
        n_table_full  = 1'b0;
        n_last        = 1'b0;
        ram_wr        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op         = i_op;
                    n_id         = i_node_id;
                    n_now        = i_now;
                    n_idx        = '0;
                    n_issue      = 1'b1;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    unique case (i_op)
                        OP_HEARTBEAT: begin
                            if (i_node_id == '0 || i_node_id == r_local_id) begin
                                // Own or null id: answer at once, no table walk.
                                n_out_valid   = 1'b1;
                                n_kind        = KIND_HEARTBEAT;
                                n_peer_id     = i_node_id;
                                n_peer_status = ST_NONE;
                                n_ignored     = 1'b1;
                                n_last        = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_TICK, OP_QUERY: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_issue = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Address side: one slot read a cycle.
                if (r_issue) begin
                    n_idx  = r_idx + 1'b1;
                    n_dvld = 1'b1;
                    n_didx = r_idx;
                    if (r_idx == SLOT_LAST) begin
                        n_issue = 1'b0;
                    end
                end
                // Data side: the slot read in the previous cycle.
                if (r_dvld) begin
                    if (hit && !r_found) begin
                        n_found     = 1'b1;
                        n_match_idx = r_didx;
                        n_match_st  = rd.status;
                    end
                    if (!r_active[r_didx] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_didx;
                    end
                    if (r_op == OP_TICK && swept) begin
                        ram_wr.addr = r_didx;
                        ram_wr.data = rd;
                        if (silence >= thr_full) begin
                            ram_wr.en          = 1'b1;
                            ram_wr.data.status = ST_DEAD;
                            n_out_valid        = 1'b1;
                            n_kind             = KIND_DEAD;
                            n_peer_id          = rd.node;
                            n_peer_status      = ST_DEAD;
                        end else if (silence >= thr_half) begin
                            ram_wr.en          = 1'b1;
                            ram_wr.data.status = ST_SUSPECT;
                        end
                    end
                    if (r_didx == SLOT_LAST) begin
                        n_state = S_FINISH;
                    end
                end
            end

            S_FINISH: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_last      = 1'b1;
                n_peer_id   = r_id;
                unique case (r_op)
                    OP_HEARTBEAT: begin
                        n_kind                = KIND_HEARTBEAT;
                        ram_wr.data.node      = r_id;
                        ram_wr.data.last_seen = r_now;
                        ram_wr.data.status    = ST_ALIVE;
                        if (r_found) begin
                            ram_wr.en     = 1'b1;
                            ram_wr.addr   = r_match_idx;
                            n_peer_status = ST_ALIVE;
                            n_came_back   = (r_match_st == ST_DEAD);
                        end else if (r_free_found) begin
                            ram_wr.en            = 1'b1;
                            ram_wr.addr          = r_free_idx;
                            n_active[r_free_idx] = 1'b1;
                            n_peer_status        = ST_ALIVE;
                        end else begin
                            n_peer_status = ST_NONE;
                            n_table_full  = 1'b1;
                        end
                    end
                    OP_TICK: begin
                        n_kind        = KIND_SWEEP_END;
                        n_peer_id     = '0;
                        n_peer_status = ST_NONE;
                    end
                    OP_QUERY: begin
                        n_kind        = KIND_STATUS;
                        n_peer_status = r_found ? r_match_st : ST_NONE;
                    end
                    default: begin
                        n_out_valid = 1'b0;
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Port drive.
    assign o_busy        = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_peer_id     = r_peer_id;
    assign o_peer_status = r_peer_status;
    assign o_came_back   = r_came_back;
    assign o_ignored     = r_ignored;
    assign o_table_full  = r_table_full;
    assign o_last        = r_last;

    // A peer-dead result only comes out in the middle of a sweep.
    a_dead_mid_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_busy && o_kind == KIND_DEAD))
        else $error("non-final result outside a sweep");

    // Heartbeat outcome flags exclude each other.
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_came_back, o_ignored, o_table_full}))
        else $error("more than one heartbeat flag set");

    // A taken request either starts a walk, answers at once, or is op 3.
    a_request_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=>
            (o_busy || o_valid || $past(i_op) == OP_UNDEFINED))
        else $error("request taken without effect");

    // A new table entry is only claimed by a heartbeat at the end of its walk.
    a_claim_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active != $past(r_active)) |->
            ($past(r_state) == S_FINISH && $past(r_op) == OP_HEARTBEAT))
        else $error("active bits changed outside a heartbeat finish");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for heartbeat_liveness_table: directed and random requests
// are predicted by an in-bench copy of the peer table and every result is checked.
// Depends on hlt_pkg and the heartbeat_liveness_table RTL.
module tb;
    import hlt_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int POOL_SIZE     = 16;

    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   node_id;
        logic [TIME_W-1:0] now;
        logic              hold;
    } t_request;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] peer_id;
        logic [1:0]      status;
        logic            came_back;
        logic            ignored;
        logic            table_full;
        logic            last;
    } t_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [1:0]           i_op;
    logic [ID_W-1:0]      i_node_id;
    logic [TIME_W-1:0]    i_now;
    logic                 o_valid;
    logic [1:0]           o_kind;
    logic [ID_W-1:0]      o_peer_id;
    logic [1:0]           o_peer_status;
    logic                 o_came_back;
    logic                 o_ignored;
    logic                 o_table_full;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    // Bench copy of the peer table and its configuration.
    bit                slot_used  [PEER_SLOTS];
    logic [ID_W-1:0]   slot_node  [PEER_SLOTS];
    logic [TIME_W-1:0] slot_seen  [PEER_SLOTS];
    logic [1:0]        slot_state [PEER_SLOTS];
    logic [31:0]       cfg_local_id  = 32'd0;
    logic [31:0]       cfg_threshold = THRESHOLD_RESET;

    t_outcome          expected_outcomes[$];
    t_request          request_q[$];
    logic [ID_W-1:0]   pool_id [POOL_SIZE];
    logic [TIME_W-1:0] stamp = '0;
    int                gap_pct = 0;
    int                n_sent = 0;
    int                n_taken = 0;
    int                error_count = 0;
    int                cycle_count = 0;

    heartbeat_liveness_table u_top (.*);

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        error_count++;
        $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    function automatic void push_outcome(input logic [1:0] kind, input logic [ID_W-1:0] peer,
                                         input logic [1:0] status, input logic back,
                                         input logic ign, input logic full, input logic fin);
        t_outcome o;
        o.kind       = kind;
        o.peer_id    = peer;
        o.status     = status;
        o.came_back  = back;
        o.ignored    = ign;
        o.table_full = full;
        o.last       = fin;
        expected_outcomes.push_back(o);
    endfunction

    function automatic int find_slot(input logic [ID_W-1:0] id);
        for (int k = 0; k < PEER_SLOTS; k++)
            if (slot_used[k] && slot_node[k] == id)
                return k;
        return -1;
    endfunction

    // Applies one accepted request to the bench table and queues its results.
    function automatic void predict_liveness(input logic [1:0] op, input logic [ID_W-1:0] id,
                                             input logic [TIME_W-1:0] now);
        int                slot;
        logic              back;
        logic [TIME_W-1:0] thr;
        logic [TIME_W-1:0] half;
        logic [TIME_W-1:0] silence;
        slot = -1;
        case (op)
            OP_HEARTBEAT: begin
                if (id == '0 || id == cfg_local_id) begin
                    push_outcome(KIND_HEARTBEAT, id, ST_NONE, 1'b0, 1'b1, 1'b0, 1'b1);
                end else begin
                    slot = find_slot(id);
                    // An unknown peer claims the lowest free entry.
                    if (slot < 0) begin
                        for (int k = 0; k < PEER_SLOTS; k++) begin
                            if (!slot_used[k] && slot < 0) begin
                                slot_used[k]  = 1'b1;
                                slot_node[k]  = id;
                                slot_state[k] = ST_ALIVE;
                                slot = k;
                            end
                        end
                    end
                    if (slot < 0) begin
                        push_outcome(KIND_HEARTBEAT, id, ST_NONE, 1'b0, 1'b0, 1'b1, 1'b1);
                    end else begin
                        slot_seen[slot]  = now;
                        back             = (slot_state[slot] == ST_DEAD);
                        slot_state[slot] = ST_ALIVE;
                        push_outcome(KIND_HEARTBEAT, id, ST_ALIVE, back, 1'b0, 1'b0, 1'b1);
                    end
                end
            end
            OP_TICK: begin
                thr  = {32'd0, cfg_threshold};
                half = thr >> 1;
                // Sweep live entries in slot order; silence wraps modulo 2^64.
                for (int k = 0; k < PEER_SLOTS; k++) begin
                    if (slot_used[k] && slot_state[k] != ST_DEAD) begin
                        silence = now - slot_seen[k];
                        if (silence >= thr) begin
                            slot_state[k] = ST_DEAD;
                            push_outcome(KIND_DEAD, slot_node[k], ST_DEAD,
                                         1'b0, 1'b0, 1'b0, 1'b0);
                        end else if (silence >= half) begin
                            slot_state[k] = ST_SUSPECT;
                        end
                    end
                end
                push_outcome(KIND_SWEEP_END, '0, ST_NONE, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            OP_QUERY: begin
                slot = find_slot(id);
                push_outcome(KIND_STATUS, id, (slot < 0) ? ST_NONE : slot_state[slot],
                             1'b0, 1'b0, 1'b0, 1'b1);
            end
            default: begin
            end
        endcase
    endfunction

    // Request driver: inputs change on the falling edge.
    always @(negedge i_clk) begin : driver
        t_request next;
        if (i_rst_n && n_taken == n_sent) begin
            if (request_q.size() != 0 && $urandom_range(99) >= gap_pct &&
                !(request_q[0].hold && (expected_outcomes.size() != 0 || o_busy))) begin
                next = request_q.pop_front();
                i_start   <= 1'b1;
                i_op      <= next.op;
                i_node_id <= next.node_id;
                i_now     <= next.now;
                n_sent++;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Result monitor and request acceptance: sampled on the rising edge.
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        string    got_s;
        string    want_s;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_outcomes.size() == 0) begin
                    report_error($sformatf("unexpected result kind %0d peer %h",
                                           o_kind, o_peer_id));
                end else begin
                    want = expected_outcomes.pop_front();
                    if (o_kind !== want.kind || o_peer_id !== want.peer_id ||
                        o_peer_status !== want.status || o_came_back !== want.came_back ||
                        o_ignored !== want.ignored || o_table_full !== want.table_full ||
                        o_last !== want.last) begin
                        got_s = $sformatf("k%0d p%h s%0d b%0d i%0d f%0d l%0d",
                                          o_kind, o_peer_id, o_peer_status, o_came_back,
                                          o_ignored, o_table_full, o_last);
                        want_s = $sformatf("k%0d p%h s%0d b%0d i%0d f%0d l%0d",
                                           want.kind, want.peer_id, want.status,
                                           want.came_back, want.ignored, want.table_full,
                                           want.last);
                        report_error({"got ", got_s, ", want ", want_s});
                    end
                end
            end
            if (i_start && !o_busy) begin
                predict_liveness(i_op, i_node_id, i_now);
                n_taken++;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic add_request(input logic [1:0] op, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] now);
        t_request r;
        r.op      = op;
        r.node_id = id;
        r.now     = now;
        r.hold    = 1'b0;
        request_q.push_back(r);
    endtask

    // Mostly well-formed traffic from a fixed set of peers on a moving clock,
    // with a little noise: stray ids, late stamps and wild fields.
    function automatic t_request random_request();
        t_request    r;
        int          pick;
        logic [31:0] thr;
        thr       = cfg_threshold;
        pick      = $urandom_range(99);
        r.hold    = ($urandom_range(99) < 2);
        r.node_id = pool_id[$urandom_range(POOL_SIZE - 1)];
        r.now     = stamp;
        if (pick < 45) begin
            r.op  = OP_HEARTBEAT;
            stamp = stamp + 64'($urandom_range(thr / 4));
            r.now = stamp;
            case ($urandom_range(19))
                0: r.node_id = '0;
                1: r.node_id = cfg_local_id;
                2: r.node_id = $urandom;
                3: r.now = stamp - 64'($urandom_range(thr));
                default: begin
                end
            endcase
        end else if (pick < 75) begin
            r.op  = OP_TICK;
            stamp = stamp + 64'($urandom_range(thr));
            r.now = stamp;
        end else if (pick < 95) begin
            r.op = OP_QUERY;
            if ($urandom_range(4) == 0)
                r.node_id = $urandom;
        end else begin
            r.op      = ($urandom_range(1) != 0) ? OP_UNDEFINED : 2'($urandom_range(2));
            r.node_id = $urandom;
            r.now     = {$urandom, $urandom};
        end
        return r;
    endfunction

    // Writes one configuration register; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LOCAL_ID)
            cfg_local_id = value;
        else
            cfg_threshold = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every request is taken and answered, then lets the block settle.
    task automatic wait_idle();
        while (request_q.size() != 0 || n_taken != n_sent ||
               expected_outcomes.size() != 0 || o_busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int gap, input logic [31:0] local_id,
                             input logic [31:0] thr, input int count);
        t_request r;
        write_reg(CFG_LOCAL_ID, local_id);
        write_reg(CFG_THRESHOLD, thr);
        gap_pct = gap;
        for (int n = 0; n < count; n++) begin
            r = random_request();
            // The opening request of each phase waits for a drained block.
            if (n == 0)
                r.hold = 1'b1;
            request_q.push_back(r);
        end
        wait_idle();
    endtask

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_op        = OP_HEARTBEAT;
        i_node_id   = '0;
        i_now       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_LOCAL_ID;
        i_cfg_data  = '0;
        pool_id[0]  = 32'd1;
        pool_id[1]  = 32'hFFFF_FFFF;
        pool_id[2]  = 32'h8000_0000;
        for (int k = 3; k < POOL_SIZE; k++)
            pool_id[k] = {16'($urandom_range(16'hFFFF, 1)), 16'(k)};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under reset configuration (threshold 300, half 150).
        add_request(OP_QUERY, pool_id[0], '0);
        add_request(OP_HEARTBEAT, '0, '0);
        add_request(OP_HEARTBEAT, pool_id[0], 64'd0);
        add_request(OP_HEARTBEAT, pool_id[1], '1);
        add_request(OP_HEARTBEAT, pool_id[2], 64'd100);
        add_request(OP_UNDEFINED, '1, '1);
        // Wrapped silence of exactly half the threshold makes a peer suspected.
        add_request(OP_TICK, '0, 64'd149);
        // Silence equal to the threshold declares peers dead.
        add_request(OP_TICK, '1, 64'd300);
        add_request(OP_QUERY, pool_id[1], '0);
        // A dead peer that speaks again comes back.
        add_request(OP_HEARTBEAT, pool_id[0], 64'd310);
        add_request(OP_TICK, '0, 64'd310);
        // Fill the rest of the table, then overflow it.
        for (int k = 3; k < POOL_SIZE; k++)
            add_request(OP_HEARTBEAT, pool_id[k], 64'd320);
        add_request(OP_HEARTBEAT, 32'h0BAD_0001, 64'd330);
        wait_idle();
        stamp = 64'd400;

        // Random phases across idling patterns and register settings.
        run_phase(0, $urandom, 32'($urandom_range(1000, 10)), 120);
        run_phase(74, 32'hFFFF_FFFF, 32'd1, 90);
        stamp = 64'hFFFF_FFFF_FFFF_FF00;
        run_phase(6, pool_id[5], 32'hFFFF_FFFF, 90);
        run_phase(74, $urandom, 32'd2, 80);
        run_phase(0, 32'd0, 32'($urandom_range(5000, 3)), 90);

        if (expected_outcomes.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_outcomes.size()));
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
hdl/hlt_pkg.sv
hdl/hlt_entry_ram.sv
hdl/heartbeat_liveness_table.sv
sim/tb.sv
